// ===== rtl/psdve_pkg.sv =====
package psdve_pkg;

    localparam int WORD_W       = 32;
    localparam int SHORT_W      = 16;
    localparam int BYTE_W       = 8;
    localparam int GROUP_W      = 7;
    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 8;
    localparam int FIELD_COUNT  = 7;
    localparam int FIELD_IDX_W  = $clog2(FIELD_COUNT);
    localparam int FIFO_DEPTH_DEFAULT = 4;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_TILT_ENABLE    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_AZIMUTH_ENABLE = 8'd1;

    // field slots in emit order
    localparam logic [FIELD_IDX_W-1:0] FLD_X       = 3'd0;
    localparam logic [FIELD_IDX_W-1:0] FLD_Y       = 3'd1;
    localparam logic [FIELD_IDX_W-1:0] FLD_PRESS   = 3'd2;
    localparam logic [FIELD_IDX_W-1:0] FLD_TIME    = 3'd3;
    localparam logic [FIELD_IDX_W-1:0] FLD_TILT_X  = 3'd4;
    localparam logic [FIELD_IDX_W-1:0] FLD_TILT_Y  = 3'd5;
    localparam logic [FIELD_IDX_W-1:0] FLD_AZIMUTH = 3'd6;

    localparam logic [GROUP_W-1:0] GROUP_MASK = 7'h7F;

    typedef struct packed {
        logic tilt_enable;
        logic azimuth_enable;
    } cfg_t;

    // one field word on its way to the serializer
    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              last;
    } field_entry_t;

endpackage

// ===== rtl/psdve_front.sv =====
module psdve_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              first_sample,
    input  logic signed [psdve_pkg::WORD_W-1:0]  pos_x,
    input  logic signed [psdve_pkg::WORD_W-1:0]  pos_y,
    input  logic        [psdve_pkg::SHORT_W-1:0] pen_pressure,
    input  logic        [psdve_pkg::WORD_W-1:0]  time_stamp,
    input  logic signed [psdve_pkg::SHORT_W-1:0] tilt_x,
    input  logic signed [psdve_pkg::SHORT_W-1:0] tilt_y,
    input  logic        [psdve_pkg::SHORT_W-1:0] azimuth,
    input  psdve_pkg::cfg_t                   cfg,
    output logic                              q_push,
    output psdve_pkg::field_entry_t           q_entry,
    input  logic                              q_full
);

    localparam int W  = psdve_pkg::WORD_W;
    localparam int SW = psdve_pkg::SHORT_W;

    function automatic logic [W-1:0] zigzag(input logic [W-1:0] d);
        zigzag = {d[W-2:0], 1'b0} ^ {W{d[W-1]}};
    endfunction

    logic [W-1:0]  prev_x_reg, prev_y_reg, prev_time_reg;
    logic [SW-1:0] prev_press_reg, prev_tilt_x_reg, prev_tilt_y_reg, prev_az_reg;
    logic [W-1:0]  field_reg [psdve_pkg::FIELD_COUNT];
    logic [W-1:0]  field_next [psdve_pkg::FIELD_COUNT];
    logic [psdve_pkg::FIELD_IDX_W-1:0] idx_reg, idx_next;
    logic          busy_reg, busy_next;
    logic          accept, field_last;

    logic [W-1:0] x_w, y_w, p_w, t_w, tx_w, ty_w, az_w;
    logic [W-1:0] px_w, py_w, pp_w, pt_w, ptx_w, pty_w, paz_w;

    assign accept = push && !busy_reg;
    assign full   = busy_reg;

    // widen to 32 bits: tilt with sign, pressure and azimuth without
    assign x_w   = $unsigned(pos_x);
    assign y_w   = $unsigned(pos_y);
    assign p_w   = {{(W-SW){1'b0}}, pen_pressure};
    assign t_w   = time_stamp;
    assign tx_w  = {{(W-SW){tilt_x[SW-1]}}, $unsigned(tilt_x)};
    assign ty_w  = {{(W-SW){tilt_y[SW-1]}}, $unsigned(tilt_y)};
    assign az_w  = {{(W-SW){1'b0}}, azimuth};
    assign px_w  = prev_x_reg;
    assign py_w  = prev_y_reg;
    assign pp_w  = {{(W-SW){1'b0}}, prev_press_reg};
    assign pt_w  = prev_time_reg;
    assign ptx_w = {{(W-SW){prev_tilt_x_reg[SW-1]}}, prev_tilt_x_reg};
    assign pty_w = {{(W-SW){prev_tilt_y_reg[SW-1]}}, prev_tilt_y_reg};
    assign paz_w = {{(W-SW){1'b0}}, prev_az_reg};

    always_comb
    begin
        if (first_sample)
        begin
            field_next[psdve_pkg::FLD_X]       = x_w;
            field_next[psdve_pkg::FLD_Y]       = y_w;
            field_next[psdve_pkg::FLD_PRESS]   = p_w;
            field_next[psdve_pkg::FLD_TIME]    = t_w;
            field_next[psdve_pkg::FLD_TILT_X]  = tx_w;
            field_next[psdve_pkg::FLD_TILT_Y]  = ty_w;
            field_next[psdve_pkg::FLD_AZIMUTH] = az_w;
        end
        else
        begin
            field_next[psdve_pkg::FLD_X]       = zigzag(x_w - px_w);
            field_next[psdve_pkg::FLD_Y]       = zigzag(y_w - py_w);
            field_next[psdve_pkg::FLD_PRESS]   = zigzag(p_w - pp_w);
            field_next[psdve_pkg::FLD_TIME]    = t_w - pt_w;
            field_next[psdve_pkg::FLD_TILT_X]  = zigzag(tx_w - ptx_w);
            field_next[psdve_pkg::FLD_TILT_Y]  = zigzag(ty_w - pty_w);
            field_next[psdve_pkg::FLD_AZIMUTH] = zigzag(az_w - paz_w);
        end
    end

    // last enabled slot ends the sample
    always_comb
    begin
        field_last = 1'b0;
        if (idx_reg == psdve_pkg::FLD_AZIMUTH)
            field_last = 1'b1;
        else if (idx_reg == psdve_pkg::FLD_TILT_Y)
            field_last = !cfg.azimuth_enable;
        else if (idx_reg == psdve_pkg::FLD_TIME)
            field_last = !cfg.tilt_enable && !cfg.azimuth_enable;
    end

    always_comb
    begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            idx_next  = psdve_pkg::FLD_X;
        end
        else if (busy_reg && !q_full)
        begin
            if (field_last)
                busy_next = 1'b0;
            else if (idx_reg == psdve_pkg::FLD_TIME && !cfg.tilt_enable)
                idx_next = psdve_pkg::FLD_AZIMUTH;
            else
                idx_next = idx_reg + 1'b1;
        end
    end

    assign q_push        = busy_reg && !q_full;
    assign q_entry.value = field_reg[idx_reg];
    assign q_entry.last  = field_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            idx_reg         <= psdve_pkg::FLD_X;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            prev_time_reg   <= '0;
            prev_press_reg  <= '0;
            prev_tilt_x_reg <= '0;
            prev_tilt_y_reg <= '0;
            prev_az_reg     <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            if (accept)
            begin
                prev_x_reg      <= x_w;
                prev_y_reg      <= y_w;
                prev_time_reg   <= t_w;
                prev_press_reg  <= pen_pressure;
                prev_tilt_x_reg <= $unsigned(tilt_x);
                prev_tilt_y_reg <= $unsigned(tilt_y);
                prev_az_reg     <= azimuth;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < psdve_pkg::FIELD_COUNT; i++)
                field_reg[i] <= field_next[i];
        end
    end

endmodule

// ===== rtl/psdve_fifo.sv =====
module psdve_fifo
#(
    parameter int DEPTH = psdve_pkg::FIFO_DEPTH_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  psdve_pkg::field_entry_t wr_entry,
    output logic                    full,
    input  logic                    rd_en,
    output psdve_pkg::field_entry_t rd_entry,
    output logic                    empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    psdve_pkg::field_entry_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    assign full     = (count_reg == DEPTH_CNT);
    assign empty    = (count_reg == '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && !empty;
    assign rd_entry = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_entry;
    end

endmodule

// ===== rtl/psdve_back.sv =====
module psdve_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    input  psdve_pkg::field_entry_t           q_entry,
    output logic                              q_pop,
    output logic                              empty,
    input  logic                              pop,
    output logic [psdve_pkg::BYTE_W-1:0]      out_byte,
    output logic                              last_byte
);

    localparam int W = psdve_pkg::WORD_W;
    localparam int G = psdve_pkg::GROUP_W;

    logic [W-1:0]                 shift_reg;
    logic                         field_last_reg;
    logic                         active_reg;
    logic                         out_valid_reg;
    logic [psdve_pkg::BYTE_W-1:0] byte_reg;
    logic                         last_reg;
    logic                         slot_free, produce, more;
    logic [G-1:0]                 group;

    assign slot_free = !out_valid_reg || pop;
    assign produce   = active_reg && slot_free;
    assign group     = shift_reg[G-1:0] & psdve_pkg::GROUP_MASK;
    assign more      = (shift_reg[W-1:G] != '0);
    // reload as soon as the current field finishes its final group
    assign q_pop     = !q_empty && (!active_reg || (produce && !more));

    assign empty     = !out_valid_reg;
    assign out_byte  = byte_reg;
    assign last_byte = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
                active_reg <= 1'b1;
            else if (produce && !more)
                active_reg <= 1'b0;

            if (produce)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            shift_reg      <= q_entry.value;
            field_last_reg <= q_entry.last;
        end
        else if (produce)
        begin
            shift_reg <= {{G{1'b0}}, shift_reg[W-1:G]};
        end
        if (produce)
        begin
            byte_reg <= {more, group};
            last_reg <= !more && field_last_reg;
        end
    end

endmodule

// ===== rtl/pen_sample_delta_varint_encoder_core.sv =====
// Path: an accepted sample passes through the front-end field registers, the field queue and the
// serializer shift register before its first byte reaches the output byte register.
// Throughput: one byte per cycle from the serializer while field words are queued and the receiver
// keeps popping; a sample emits 4 to 35 bytes from its 4 to 7 enabled field words.
// The front end takes a new sample once its last field word has entered the field queue.
// Reset (rst_n low, asynchronous) clears the previous-sample store, both enables, the queue
// and all valid flags; the block is ready as soon as reset is released.
module pen_sample_delta_varint_encoder_core
#(
    parameter int FIFO_DEPTH = psdve_pkg::FIFO_DEPTH_DEFAULT
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // sample input, queue style
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  first_sample,
    input  logic signed [psdve_pkg::WORD_W-1:0]   pos_x,
    input  logic signed [psdve_pkg::WORD_W-1:0]   pos_y,
    input  logic        [psdve_pkg::SHORT_W-1:0]  pen_pressure,
    input  logic        [psdve_pkg::WORD_W-1:0]   time_stamp,
    input  logic signed [psdve_pkg::SHORT_W-1:0]  tilt_x,
    input  logic signed [psdve_pkg::SHORT_W-1:0]  tilt_y,
    input  logic        [psdve_pkg::SHORT_W-1:0]  azimuth,
    // byte output, queue style
    output logic                                  empty,
    input  logic                                  pop,
    output logic        [psdve_pkg::BYTE_W-1:0]   out_byte,
    output logic                                  last_byte,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic        [psdve_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic        [psdve_pkg::CFG_DATA_W-1:0]  cfg_data
);

    psdve_pkg::cfg_t          cfg_reg;
    psdve_pkg::field_entry_t  front_entry;
    psdve_pkg::field_entry_t  back_entry;
    logic                     front_push;
    logic                     fifo_full;
    logic                     fifo_empty;
    logic                     back_pop;

    // Register writes are never stalled and land in the enable register at the clock
    // edge; only bit 0 of the data counts and indexes past the two enables are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                psdve_pkg::CFG_TILT_ENABLE:    cfg_reg.tilt_enable    <= cfg_data[0];
                psdve_pkg::CFG_AZIMUTH_ENABLE: cfg_reg.azimuth_enable <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Front end: capture a sample, form raw words or delta words (zigzag for all but
    // time) for all seven fields, update the previous-sample store, then hand the
    // enabled words to the queue one per cycle while it has room, final one marked.
    psdve_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .first_sample (first_sample),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pen_pressure (pen_pressure),
        .time_stamp   (time_stamp),
        .tilt_x       (tilt_x),
        .tilt_y       (tilt_y),
        .azimuth      (azimuth),
        .cfg          (cfg_reg),
        .q_push       (front_push),
        .q_entry      (front_entry),
        .q_full       (fifo_full)
    );

    // Short field queue decouples word generation from byte serialization.
    psdve_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_push),
        .wr_entry (front_entry),
        .full     (fifo_full),
        .rd_en    (back_pop),
        .rd_entry (back_entry),
        .empty    (fifo_empty)
    );

    // Back end: split each word into 7-bit groups, low group first, continuation
    // flag on all but the final group; the byte register holds a waiting transaction.
    psdve_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (fifo_empty),
        .q_entry   (back_entry),
        .q_pop     (back_pop),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

endmodule

// ===== rtl/psdve_checker.sv =====
module psdve_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic                                 full,
    input  logic                                 empty,
    input  logic                                 pop,
    input  logic [psdve_pkg::BYTE_W-1:0]         out_byte,
    input  logic                                 last_byte,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready
);

    // a waiting byte holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last_byte)))
        else $error("result changed while stalled");

    // an accepted sample keeps the front end busy for at least the next cycle
    a_busy_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> full)
        else $error("front end free right after a transaction");

    // a continuation byte never closes a sample
    a_last_no_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_byte[7]) |-> !last_byte)
        else $error("last byte carries continuation flag");

    // register writes never stall
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind pen_sample_delta_varint_encoder_core psdve_checker u_psdve_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .last_byte (last_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

// ===== verif/psdve_stream_checker.sv =====
module psdve_stream_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic                                 full,
    input  logic                                 first_sample,
    input  logic [psdve_pkg::WORD_W-1:0]         pos_x,
    input  logic [psdve_pkg::WORD_W-1:0]         pos_y,
    input  logic [psdve_pkg::SHORT_W-1:0]        pen_pressure,
    input  logic [psdve_pkg::WORD_W-1:0]         time_stamp,
    input  logic [psdve_pkg::SHORT_W-1:0]        tilt_x,
    input  logic [psdve_pkg::SHORT_W-1:0]        tilt_y,
    input  logic [psdve_pkg::SHORT_W-1:0]        azimuth,
    input  logic                                 empty,
    input  logic                                 pop,
    input  logic [psdve_pkg::BYTE_W-1:0]         out_byte,
    input  logic                                 last_byte,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [psdve_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [psdve_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                   mismatch_count,
    output int                                   bytes_owed
);

    localparam int WORD_W  = psdve_pkg::WORD_W;
    localparam int SHORT_W = psdve_pkg::SHORT_W;
    localparam int BYTE_W  = psdve_pkg::BYTE_W;
    localparam int GROUP_W = psdve_pkg::GROUP_W;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } enc_byte_t;

    enc_byte_t owed_q[$];

    logic               tilt_on;
    logic               az_on;
    logic [WORD_W-1:0]  prior_x;
    logic [WORD_W-1:0]  prior_y;
    logic [WORD_W-1:0]  prior_time;
    logic [SHORT_W-1:0] prior_press;
    logic [SHORT_W-1:0] prior_tilt_x;
    logic [SHORT_W-1:0] prior_tilt_y;
    logic [SHORT_W-1:0] prior_az;

    initial begin
        mismatch_count = 0;
        bytes_owed     = 0;
    end

    function automatic logic [WORD_W-1:0] zigzag(input logic [WORD_W-1:0] d);
        return {d[WORD_W-2:0], 1'b0} ^ {WORD_W{d[WORD_W-1]}};
    endfunction

    function automatic logic [WORD_W-1:0] widen_signed(input logic [SHORT_W-1:0] v);
        return {{(WORD_W-SHORT_W){v[SHORT_W-1]}}, v};
    endfunction

    function automatic logic [WORD_W-1:0] widen_unsigned(input logic [SHORT_W-1:0] v);
        return {{(WORD_W-SHORT_W){1'b0}}, v};
    endfunction

    // LEB128: low 7-bit group first, bit 7 marks more groups to come
    function automatic void append_leb128(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] rest;
        enc_byte_t         b;
        rest = v;
        do begin
            b.data = {1'b0, rest[GROUP_W-1:0]};
            rest   = rest >> GROUP_W;
            b.data[BYTE_W-1] = (rest != '0);
            b.last = 1'b0;
            owed_q = {owed_q, b};
        end while (rest != '0);
    endfunction

    function automatic void encode_sample();
        enc_byte_t tail;
        if (first_sample) begin
            append_leb128(pos_x);
            append_leb128(pos_y);
            append_leb128(widen_unsigned(pen_pressure));
            append_leb128(time_stamp);
            if (tilt_on) begin
                append_leb128(widen_signed(tilt_x));
                append_leb128(widen_signed(tilt_y));
            end
            if (az_on)
                append_leb128(widen_unsigned(azimuth));
        end
        else begin
            append_leb128(zigzag(pos_x - prior_x));
            append_leb128(zigzag(pos_y - prior_y));
            append_leb128(zigzag(widen_unsigned(pen_pressure) - widen_unsigned(prior_press)));
            append_leb128(time_stamp - prior_time);
            if (tilt_on) begin
                append_leb128(zigzag(widen_signed(tilt_x) - widen_signed(prior_tilt_x)));
                append_leb128(zigzag(widen_signed(tilt_y) - widen_signed(prior_tilt_y)));
            end
            if (az_on)
                append_leb128(zigzag(widen_unsigned(azimuth) - widen_unsigned(prior_az)));
        end
        tail = owed_q.pop_back();
        tail.last = 1'b1;
        owed_q = {owed_q, tail};
        // store every field, enabled or not
        prior_x      = pos_x;
        prior_y      = pos_y;
        prior_press  = pen_pressure;
        prior_time   = time_stamp;
        prior_tilt_x = tilt_x;
        prior_tilt_y = tilt_y;
        prior_az     = azimuth;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        enc_byte_t want;
        if (!rst_n) begin
            owed_q.delete();
            tilt_on      = 1'b0;
            az_on        = 1'b0;
            prior_x      = '0;
            prior_y      = '0;
            prior_time   = '0;
            prior_press  = '0;
            prior_tilt_x = '0;
            prior_tilt_y = '0;
            prior_az     = '0;
        end
        else begin
            // check the popped byte before queueing new ones
            if (pop && !empty) begin
                if (owed_q.size() == 0) begin
                    $display("%0t: unexpected byte, expected none, got %02h last %b",
                             $time, out_byte, last_byte);
                    mismatch_count++;
                end
                else begin
                    want = owed_q.pop_front();
                    if (out_byte !== want.data) begin
                        $display("%0t: out_byte expected %02h got %02h",
                                 $time, want.data, out_byte);
                        mismatch_count++;
                    end
                    if (last_byte !== want.last) begin
                        $display("%0t: last_byte expected %b got %b",
                                 $time, want.last, last_byte);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    psdve_pkg::CFG_TILT_ENABLE:    tilt_on = cfg_data[0];
                    psdve_pkg::CFG_AZIMUTH_ENABLE: az_on   = cfg_data[0];
                    default: ;
                endcase
            end
            if (push && !full)
                encode_sample();
        end
        bytes_owed = owed_q.size();
    end

endmodule

// ===== verif/pen_sample_delta_varint_encoder_core_tb.sv =====
module pen_sample_delta_varint_encoder_core_tb;

    localparam int WORD_W      = psdve_pkg::WORD_W;
    localparam int SHORT_W     = psdve_pkg::SHORT_W;
    localparam int BYTE_W      = psdve_pkg::BYTE_W;
    localparam int CFG_INDEX_W = psdve_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = psdve_pkg::CFG_DATA_W;

    // Run budget: ~275 samples of at most 35 bytes, receiver idle half the time,
    // plus two long hold-offs; the limit is many times that.
    localparam int CYCLE_LIMIT     = 200000;
    localparam int CHOKE_CYCLES    = 300;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 43;
    localparam int SETTLE_CYCLES   = 8;

    // any index past the two real registers must be dropped by the block
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_UNUSED = 8'd2;

    typedef struct packed {
        logic               first;
        logic [WORD_W-1:0]  x;
        logic [WORD_W-1:0]  y;
        logic [SHORT_W-1:0] press;
        logic [WORD_W-1:0]  t;
        logic [SHORT_W-1:0] tx;
        logic [SHORT_W-1:0] ty;
        logic [SHORT_W-1:0] az;
    } pen_sample_t;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        push         = 1'b0;
    logic                        full;
    logic                        first_sample = 1'b0;
    logic signed [WORD_W-1:0]    pos_x        = '0;
    logic signed [WORD_W-1:0]    pos_y        = '0;
    logic        [SHORT_W-1:0]   pen_pressure = '0;
    logic        [WORD_W-1:0]    time_stamp   = '0;
    logic signed [SHORT_W-1:0]   tilt_x       = '0;
    logic signed [SHORT_W-1:0]   tilt_y       = '0;
    logic        [SHORT_W-1:0]   azimuth      = '0;
    logic                        empty;
    logic                        pop          = 1'b0;
    logic        [BYTE_W-1:0]    out_byte;
    logic                        last_byte;
    logic                        cfg_valid    = 1'b0;
    logic                        cfg_ready;
    logic        [CFG_INDEX_W-1:0] cfg_index  = '0;
    logic        [CFG_DATA_W-1:0]  cfg_data   = '0;

    int chk_errors;
    int bytes_owed;
    int cycle_count  = 0;
    int send_gap     = 0;   // percent of cycles the sample side sits idle
    int recv_gap     = 0;   // percent of cycles the byte side declines to pop
    int choke_asked  = 0;   // bumped by stimulus, honored by the pop process
    int choke_seen   = 0;
    int stall_left   = 0;

    pen_sample_delta_varint_encoder_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .first_sample (first_sample),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pen_pressure (pen_pressure),
        .time_stamp   (time_stamp),
        .tilt_x       (tilt_x),
        .tilt_y       (tilt_y),
        .azimuth      (azimuth),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .last_byte    (last_byte),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    psdve_stream_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .first_sample   (first_sample),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pen_pressure   (pen_pressure),
        .time_stamp     (time_stamp),
        .tilt_x         (tilt_x),
        .tilt_y         (tilt_y),
        .azimuth        (azimuth),
        .empty          (empty),
        .pop            (pop),
        .out_byte       (out_byte),
        .last_byte      (last_byte),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (chk_errors),
        .bytes_owed     (bytes_owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a missing byte ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Byte side. Pop decisions are made on the falling edge so they are stable at
    // the next rising edge. A choke request holds pop low for a long stretch so the
    // block's internal queue fills and it has to raise full against the sender.
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (stall_left > 0)
        begin
            pop <= 1'b0;
            stall_left--;
        end
        else if (choke_asked != choke_seen)
        begin
            choke_seen = choke_asked;
            stall_left = CHOKE_CYCLES - 1;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= recv_gap);
    end

    function automatic pen_sample_t make_sample(input logic               first,
                                                input logic [WORD_W-1:0]  x,
                                                input logic [WORD_W-1:0]  y,
                                                input logic [SHORT_W-1:0] press,
                                                input logic [WORD_W-1:0]  t,
                                                input logic [SHORT_W-1:0] tx,
                                                input logic [SHORT_W-1:0] ty,
                                                input logic [SHORT_W-1:0] az);
        pen_sample_t s;
        s.first = first;
        s.x     = x;
        s.y     = y;
        s.press = press;
        s.t     = t;
        s.tx    = tx;
        s.ty    = ty;
        s.az    = az;
        return s;
    endfunction

    // Move a value by a random step; the wide span lets deltas wrap at 32 bits.
    function automatic logic [WORD_W-1:0] nudge(input logic [WORD_W-1:0] v);
        int unsigned span;
        case ($urandom_range(3))
            0:       span = 63;
            1:       span = 9000;
            2:       span = 300000;
            default: span = 32'h3FFF_FFFF;
        endcase
        return v + $urandom_range(2 * span) - span;
    endfunction

    // Zero, all ones, most negative or most positive for a field of width w.
    function automatic logic [WORD_W-1:0] corner(input int unsigned w);
        logic [WORD_W-1:0] c;
        case ($urandom_range(3))
            0:       c = '0;
            1:       c = '1;
            2:       c = WORD_W'(1) << (w - 1);
            default: c = (WORD_W'(1) << (w - 1)) - 1;
        endcase
        return c;
    endfunction

    // Mostly pen-like motion (small steps within a stroke, time moving forward),
    // with some fully random samples and some corner values mixed in.
    function automatic pen_sample_t next_sample(input pen_sample_t prev);
        pen_sample_t       s;
        logic [WORD_W-1:0] w;
        int unsigned       mode;
        mode    = $urandom_range(99);
        s.first = ($urandom_range(99) < 12);
        if (mode < 70)
        begin
            s.x = nudge(prev.x);
            s.y = nudge(prev.y);
            w = nudge({16'h0, prev.press}); s.press = w[SHORT_W-1:0];
            s.t = prev.t + $urandom_range(20000);
            w = nudge({16'h0, prev.tx});    s.tx    = w[SHORT_W-1:0];
            w = nudge({16'h0, prev.ty});    s.ty    = w[SHORT_W-1:0];
            w = nudge({16'h0, prev.az});    s.az    = w[SHORT_W-1:0];
        end
        else if (mode < 88)
        begin
            s.x = $urandom;
            s.y = $urandom;
            s.t = $urandom;
            w = $urandom; s.press = w[SHORT_W-1:0];
            w = $urandom; s.tx    = w[SHORT_W-1:0];
            w = $urandom; s.ty    = w[SHORT_W-1:0];
            w = $urandom; s.az    = w[SHORT_W-1:0];
        end
        else
        begin
            s.x = corner(WORD_W);
            s.y = corner(WORD_W);
            s.t = corner(WORD_W);
            w = corner(SHORT_W); s.press = w[SHORT_W-1:0];
            w = corner(SHORT_W); s.tx    = w[SHORT_W-1:0];
            w = corner(SHORT_W); s.ty    = w[SHORT_W-1:0];
            w = corner(SHORT_W); s.az    = w[SHORT_W-1:0];
        end
        return s;
    endfunction

    // Called on a falling edge; returns on the falling edge after the transaction
    // with push still high, so a back-to-back sample never lowers and re-raises it.
    task automatic send_sample(input pen_sample_t s);
        while ($urandom_range(99) < send_gap)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push         <= 1'b1;
        first_sample <= s.first;
        pos_x        <= s.x;
        pos_y        <= s.y;
        pen_pressure <= s.press;
        time_stamp   <= s.t;
        tilt_x       <= s.tx;
        tilt_y       <= s.ty;
        azimuth      <= s.az;
        do @(posedge clk); while (full);
        @(negedge clk);
    endtask

    // Drop push, then hold until every queued byte has been popped and checked.
    task automatic drain();
        push <= 1'b0;
        while (bytes_owed != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One write transaction; leaves valid high so back-to-back writes stay clean.
    task automatic cfg_beat(input logic [CFG_INDEX_W-1:0] idx, input logic val);
        logic [CFG_DATA_W-1:0] d;
        d    = CFG_DATA_W'($urandom);   // upper bits are don't-care to the block
        d[0] = val;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // Write both enables, then poke an unused index that must not disturb them.
    task automatic set_enables(input logic tilt_en, input logic az_en);
        logic [CFG_INDEX_W-1:0] junk;
        junk = CFG_INDEX_W'($urandom_range(255, CFG_FIRST_UNUSED));
        cfg_beat(psdve_pkg::CFG_TILT_ENABLE, tilt_en);
        cfg_beat(psdve_pkg::CFG_AZIMUTH_ENABLE, az_en);
        cfg_beat(junk, 1'($urandom_range(1)));
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        pen_sample_t prev;
        int          ph;
        int          i;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Sender idles 10%, receiver 49%.
        send_gap = 10;
        recv_gap = 49;

        // Enables are off out of reset. Open without a stroke mark so the deltas are
        // taken against the zeroed history; tilt and azimuth must still be stored.
        send_sample(make_sample(1'b0, 32'hFFFF_FFFB, 32'h0000_0007, 16'h012C,
                                32'h0000_03E8, 16'hFF9C, 16'h0032, 16'h04D2));
        send_sample(make_sample(1'b0, 32'hFFFF_FFF0, 32'h0000_0010, 16'h0100,
                                32'h0000_0400, 16'h8000, 16'h7FFF, 16'hFFFF));
        drain();
        set_enables(1'b1, 1'b1);

        // Tilt/azimuth deltas against values stored while their output was off.
        send_sample(make_sample(1'b0, 32'hFFFF_FFF0, 32'h0000_0010, 16'h0100,
                                32'h0000_0400, 16'h7FFF, 16'h8000, 16'h0000));
        // Raw extremes at stroke start.
        send_sample(make_sample(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF,
                                32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 16'hFFFF));
        // Every delta wraps: coordinates and time roll over, shorts swing full range.
        send_sample(make_sample(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000,
                                32'h0000_0000, 16'h8000, 16'h7FFF, 16'h0000));
        // Repeat: all deltas zero, one byte per field.
        send_sample(make_sample(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000,
                                32'h0000_0000, 16'h8000, 16'h7FFF, 16'h0000));
        // Raw zeros, then raw negatives that sign-extend to five bytes.
        send_sample(make_sample(1'b1, 32'h0, 32'h0, 16'h0, 32'h0, 16'h0, 16'h0, 16'h0));
        send_sample(make_sample(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000,
                                32'h0000_0000, 16'hFFFF, 16'hFFFF, 16'h0000));
        // Zigzag byte-count boundaries: +64/-64, +8191/-8192.
        send_sample(make_sample(1'b0, 32'h0000_003F, 32'hFFFF_FFBF, 16'h0040,
                                32'h0000_007F, 16'h003F, 16'hFFBF, 16'h0040));
        send_sample(make_sample(1'b0, 32'h0000_203E, 32'hDFFF_FFBF, 16'h2040,
                                32'h0000_407F, 16'h203E, 16'hDFBF, 16'h2040));
        // Unsigned time delta of one and pressure falling to zero.
        send_sample(make_sample(1'b0, 32'h0000_203E, 32'hDFFF_FFBF, 16'h0000,
                                32'h0000_4080, 16'h203E, 16'hDFBF, 16'h0000));
        drain();

        set_enables(1'b0, 1'b1);
        send_sample(make_sample(1'b1, 32'h1234_5678, 32'h9ABC_DEF0, 16'h5555,
                                32'hAAAA_AAAA, 16'h1234, 16'hEDCB, 16'hAAAA));
        send_sample(make_sample(1'b0, 32'h1234_5600, 32'h9ABC_DF00, 16'h5500,
                                32'hAAAA_AB00, 16'h0000, 16'h0000, 16'hAA00));
        drain();

        set_enables(1'b1, 1'b0);
        send_sample(make_sample(1'b0, 32'h1234_5601, 32'h9ABC_DEFF, 16'h5501,
                                32'hAAAA_AB01, 16'hFFFF, 16'h0001, 16'hAA01));
        send_sample(make_sample(1'b1, 32'h0000_0001, 32'h0000_0080, 16'h4000,
                                32'h0020_0000, 16'h0080, 16'hFF80, 16'h0000));
        drain();

        // Random part. Phases walk through every enable combination and the three
        // idle patterns; each phase starts from a drained block.
        prev = make_sample(1'b1, 32'h0, 32'h0, 16'h0, 32'h0, 16'h0, 16'h0, 16'h0);
        for (ph = 0; ph < PHASES; ph++)
        begin
            drain();
            case (ph)
                0:       set_enables(1'b1, 1'b1);
                1:       set_enables(1'b0, 1'b0);
                2:       set_enables(1'b1, 1'b0);
                3:       set_enables(1'b0, 1'b1);
                4:       set_enables(1'b1, 1'b1);
                default: set_enables(1'($urandom_range(1)), 1'($urandom_range(1)));
            endcase
            if (ph < 2)
            begin
                send_gap = 10;
                recv_gap = 49;
            end
            else if (ph < 4)
            begin
                send_gap = 49;
                recv_gap = 10;
            end
            else
            begin
                send_gap = 0;
                recv_gap = 0;
            end
            // Each phase opens with a marked first sample.
            prev.first = 1'b1;
            send_sample(prev);
            for (i = 1; i < ITEMS_PER_PHASE; i++)
            begin
                // Long receiver hold-off while the sender keeps offering samples.
                if ((ph == 4 || ph == 2) && i == 10)
                    choke_asked++;
                prev = next_sample(prev);
                send_sample(prev);
            end
        end

        drain();
        if (chk_errors == 0 && bytes_owed == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
